### sv/rendezvous_join_slots_macros.svh
// ---------------------------------------------------------------------------
// rendezvous_join_slots_macros.svh
// Assertion macros used by the checker of the rendezvous join block.
// ---------------------------------------------------------------------------
`ifndef RENDEZVOUS_JOIN_SLOTS_MACROS_SVH
`define RENDEZVOUS_JOIN_SLOTS_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RJS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rendezvous_join_slots: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rendezvous_join_slots: assertion failed");

`endif

### sv/rjs_pkg.sv
// ---------------------------------------------------------------------------
// rjs_pkg
// Types and constants of the rendezvous join block.
// ---------------------------------------------------------------------------
`default_nettype none

package rjs_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ACTIVE_W = 4;
	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned KIND_W   = 2;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd2;

	// input action codes
	localparam logic ACTION_STORE = 1'b0;
	localparam logic ACTION_CLEAR = 1'b1;

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_BANG  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLOAT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LIST  = 2'd3;

	// slot occupancy tag; a filled tag minus one is the output kind
	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_INT   = 2'd1,
		TAG_FLOAT = 2'd2,
		TAG_LIST  = 2'd3
	} tag_t;

	typedef struct packed {
		logic clear;
		logic write;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### sv/rjs_in_if.sv
// ---------------------------------------------------------------------------
// rjs_in_if
// Input channel: one tagged value addressed to a slot.
// ---------------------------------------------------------------------------
`default_nettype none

interface rjs_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [rjs_pkg::SLOT_W-1:0]    slot_index;
	logic [rjs_pkg::KIND_W-1:0]    kind;
	logic [rjs_pkg::DATA_W-1:0]    payload;

	modport source (output valid, action, slot_index, kind, payload, input ready);
	modport sink   (input valid, action, slot_index, kind, payload, output ready);
endinterface

`default_nettype wire

### sv/rjs_out_if.sv
// ---------------------------------------------------------------------------
// rjs_out_if
// Output channel: one released slot value.
// ---------------------------------------------------------------------------
`default_nettype none

interface rjs_out_if;
	logic                          valid;
	logic                          ready;
	logic [rjs_pkg::SLOT_W-1:0]    out_slot;
	logic [rjs_pkg::KIND_W-1:0]    out_kind;
	logic [rjs_pkg::DATA_W-1:0]    out_payload;
	logic                          last;

	modport source (output valid, out_slot, out_kind, out_payload, last, input ready);
	modport sink   (input valid, out_slot, out_kind, out_payload, last, output ready);
endinterface

`default_nettype wire

### sv/rjs_cell.sv
// ---------------------------------------------------------------------------
// rjs_cell
// One slot: tag and value, loaded directly or shifted from the lower cell.
// ---------------------------------------------------------------------------
`default_nettype none

module rjs_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rjs_pkg::cell_ctrl_t        ctrl,
	input  rjs_pkg::tag_t              wr_tag,
	input  logic [rjs_pkg::DATA_W-1:0] wr_data,
	input  rjs_pkg::tag_t              prev_tag,
	input  logic [rjs_pkg::DATA_W-1:0] prev_data,
	output rjs_pkg::tag_t              tag,
	output logic [rjs_pkg::DATA_W-1:0] data
);

	rjs_pkg::tag_t              tag_q;
	logic [rjs_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= rjs_pkg::TAG_EMPTY;
		end else begin
			priority if (ctrl.clear) begin
				tag_q <= rjs_pkg::TAG_EMPTY;
			end else if (ctrl.write) begin
				tag_q <= wr_tag;
			end else if (ctrl.shift) begin
				tag_q <= prev_tag;
			end else begin
				tag_q <= tag_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.write) begin
			data_q <= wr_data;
		end else if (ctrl.shift) begin
			data_q <= prev_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign tag  = tag_q;
	assign data = data_q;

endmodule

`default_nettype wire

### sv/rendezvous_join_slots.sv
// ---------------------------------------------------------------------------
// rendezvous_join_slots
// Join barrier with data slots: collects one value per active slot, then
// releases them all from the highest slot down to slot 0.
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake     carries
//   in_ch     in   valid/ready   action, slot_index, kind, payload
//   out_ch    out  valid/ready   out_slot, out_kind, out_payload, last
//   cfg       in   cfg_we        cfg_wdata -> active_slots
//
// The transaction that fills the last empty active slot starts a release
// of n transactions (n = active slot count), one per cycle, paced by the
// shift of the cell row into the output register; in_ch.ready stays low
// for the whole release.
// A stall on out_ch freezes the row; the output register holds its item.
// Reset empties every slot and sets the active count to 2. No clearing pass.
//
`default_nettype none

module rendezvous_join_slots #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rjs_in_if.sink                         in_ch,
	rjs_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [rjs_pkg::ACTIVE_W-1:0]   cfg_wdata
);

	// count width holds NUM_SLOTS itself; cell index width addresses the row
	localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CMP_W = (CNT_W > rjs_pkg::ACTIVE_W) ? CNT_W : rjs_pkg::ACTIVE_W;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_RELEASE = 2'b10
	} state_t;

	state_t                         state_q;
	logic [rjs_pkg::ACTIVE_W-1:0]   active_q;
	logic [CNT_W-1:0]               filled_q;
	logic [CNT_W-1:0]               rel_left_q;

	logic                           out_valid_q;
	logic [rjs_pkg::SLOT_W-1:0]     out_slot_q;
	logic [rjs_pkg::KIND_W-1:0]     out_kind_q;
	logic [rjs_pkg::DATA_W-1:0]     out_payload_q;
	logic                           out_last_q;

	// active count, clamped to 1..NUM_SLOTS
	logic [CMP_W-1:0]               active_ext;
	logic [CMP_W-1:0]               n_cmp;
	logic [CNT_W-1:0]               n_cnt;

	always_comb begin
		active_ext = CMP_W'(active_q);
		priority if (active_ext == '0) begin
			n_cmp = CMP_W'(1);
		end else if (active_ext > CMP_W'(NUM_SLOTS)) begin
			n_cmp = CMP_W'(NUM_SLOTS);
		end else begin
			n_cmp = active_ext;
		end
		n_cnt = CNT_W'(n_cmp);
	end

	// input decode
	logic                           in_acc;
	logic                           in_range;
	logic                           clear_word0;
	logic                           store_ok;
	logic                           clear_all;
	rjs_pkg::tag_t                  wr_tag;
	logic [rjs_pkg::DATA_W-1:0]     wr_data;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_range    = CMP_W'(in_ch.slot_index) < n_cmp;
	assign clear_word0 = in_acc && in_range && (in_ch.action == rjs_pkg::ACTION_CLEAR)
	                     && (in_ch.slot_index == '0);
	assign store_ok    = in_acc && in_range && !clear_word0;
	// drop every slot on a clear word to slot 0 or on any reconfiguration
	assign clear_all   = clear_word0 || cfg_we;

	always_comb begin
		priority if (in_ch.action == rjs_pkg::ACTION_CLEAR) begin
			// the clear word on another slot lands as a list handle
			wr_tag  = rjs_pkg::TAG_LIST;
			wr_data = in_ch.payload;
		end else if (in_ch.kind == rjs_pkg::KIND_BANG) begin
			wr_tag  = rjs_pkg::TAG_INT;
			wr_data = '0;
		end else begin
			wr_tag  = rjs_pkg::tag_t'(in_ch.kind);
			wr_data = in_ch.payload;
		end
	end

	// release pacing: advance the row whenever the output register frees up
	logic                           rel_step;
	assign rel_step = (state_q == ST_RELEASE) && (!out_valid_q || out_ch.ready);

	// cell row
	rjs_pkg::tag_t                  tag_arr  [NUM_SLOTS];
	logic [rjs_pkg::DATA_W-1:0]     data_arr [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]           cell_hit;
	logic [NUM_SLOTS-1:0]           cell_empty;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		rjs_pkg::cell_ctrl_t        ctrl;
		rjs_pkg::tag_t              prev_tag;
		logic [rjs_pkg::DATA_W-1:0] prev_data;

		assign cell_hit[i]   = ({{(32 - rjs_pkg::SLOT_W){1'b0}}, in_ch.slot_index} == 32'(i));
		assign cell_empty[i] = (tag_arr[i] == rjs_pkg::TAG_EMPTY);

		assign ctrl.clear = clear_all;
		assign ctrl.write = store_ok && cell_hit[i];
		// only active cells move, so cells above the active range stay empty
		assign ctrl.shift = rel_step && (CNT_W'(i) < n_cnt);

		if (i == 0) begin : g_head
			// feed empty slots in behind the release
			assign prev_tag  = rjs_pkg::TAG_EMPTY;
			assign prev_data = '0;
		end else begin : g_body
			assign prev_tag  = tag_arr[i-1];
			assign prev_data = data_arr[i-1];
		end

		rjs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.wr_tag    (wr_tag),
			.wr_data   (wr_data),
			.prev_tag  (prev_tag),
			.prev_data (prev_data),
			.tag       (tag_arr[i]),
			.data      (data_arr[i])
		);
	end

	// count first fills only
	logic                           hit_empty;
	logic [CNT_W-1:0]               filled_next;
	logic                           rel_start;

	assign hit_empty   = |(cell_hit & cell_empty);
	assign filled_next = filled_q + CNT_W'(hit_empty);
	assign rel_start   = store_ok && (filled_next == n_cnt);

	// tap of the row: the highest active cell
	logic [CNT_W-1:0]               top_idx;
	logic [CNT_W-1:0]               rel_m1;
	rjs_pkg::tag_t                  top_tag;

	assign top_idx = n_cnt - CNT_W'(1);
	assign rel_m1  = rel_left_q - CNT_W'(1);
	assign top_tag = tag_arr[top_idx[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= rjs_pkg::ACTIVE_RESET;
			filled_q   <= '0;
			rel_left_q <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					priority if (clear_all) begin
						filled_q <= '0;
					end else if (rel_start) begin
						// empty the count now; the row drains over the release
						filled_q   <= '0;
						rel_left_q <= n_cnt;
						state_q    <= ST_RELEASE;
					end else if (store_ok) begin
						filled_q <= filled_next;
					end else begin
						filled_q <= filled_q;
					end
				end
				ST_RELEASE: begin
					if (rel_step) begin
						rel_left_q <= rel_m1;
						if (rel_left_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (rel_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rel_step) begin
			out_slot_q    <= rjs_pkg::SLOT_W'(rel_m1);
			out_kind_q    <= rjs_pkg::KIND_W'(top_tag) - rjs_pkg::KIND_W'(1);
			out_payload_q <= data_arr[top_idx[IDX_W-1:0]];
			out_last_q    <= (rel_left_q == CNT_W'(1));
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_slot    = out_slot_q;
	assign out_ch.out_kind    = out_kind_q;
	assign out_ch.out_payload = out_payload_q;
	assign out_ch.last        = out_last_q;

endmodule

`default_nettype wire

### sv/rjs_checker.sv
// ---------------------------------------------------------------------------
// rjs_checker
// Port-level checks of the rendezvous join block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rendezvous_join_slots_macros.svh"

module rjs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [rjs_pkg::SLOT_W-1:0]     out_slot,
	input logic [rjs_pkg::KIND_W-1:0]     out_kind,
	input logic [rjs_pkg::DATA_W-1:0]     out_payload,
	input logic                           last
);

	// a release in progress holds off input
	`RJS_ASSERT_SAME(a_release_blocks_input, clk, arst_n, out_valid && !last, !in_ready)

	// the final transaction of a release is always slot 0
	`RJS_ASSERT_SAME(a_last_is_slot0, clk, arst_n, out_valid && last, out_slot == '0)

	// an empty slot is never released
	`RJS_ASSERT_SAME(a_kind_filled, clk, arst_n, out_valid, out_kind != 2'd3)

	// a stalled transaction holds
	`RJS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_payload) && $stable(out_slot))

endmodule

bind rendezvous_join_slots rjs_checker u_rjs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_slot    (out_ch.out_slot),
	.out_kind    (out_ch.out_kind),
	.out_payload (out_ch.out_payload),
	.last        (out_ch.last)
);

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the rendezvous join with data slots. A queue of
// transactions feeds a falling-edge driver; a rising-edge monitor mirrors
// every accepted store or clear in a local slot model, and checks each
// released value, in order, against the values that model predicts.
// ---------------------------------------------------------------------------

module testbench;

	localparam int unsigned SLOTS         = 8;
	localparam int unsigned MAX_GAP       = 12;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT   = 1000;
	localparam int unsigned RANDOM_ITEMS  = 250;
	localparam int unsigned PHASES        = 12;

	// one inbound transaction; drain_first makes the driver wait until every
	// predicted release has come back before presenting it
	typedef struct {
		logic                         action;
		logic [rjs_pkg::SLOT_W-1:0]   slot_index;
		logic [rjs_pkg::KIND_W-1:0]   kind;
		logic [rjs_pkg::DATA_W-1:0]   payload;
		bit                           drain_first;
	} join_item_t;

	typedef struct packed {
		logic [rjs_pkg::SLOT_W-1:0]   out_slot;
		logic [rjs_pkg::KIND_W-1:0]   out_kind;
		logic [rjs_pkg::DATA_W-1:0]   out_payload;
		logic                         last;
	} release_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rjs_pkg::ACTIVE_W-1:0]   cfg_wdata;

	rjs_in_if  in_ch ();
	rjs_out_if out_ch ();

	rendezvous_join_slots #(
		.NUM_SLOTS (SLOTS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// slot model: configured width, per-slot tag and value, fill count
	logic [rjs_pkg::ACTIVE_W-1:0]   span_reg;
	rjs_pkg::tag_t                  held_tag [SLOTS];
	logic [rjs_pkg::DATA_W-1:0]     held_val [SLOTS];
	int unsigned                    held_count;

	join_item_t           stimulus_q [$];
	release_t             release_q [$];
	join_item_t           next_item;

	int unsigned          queued_total = 0;
	int unsigned          taken_total  = 0;
	int unsigned          mismatches   = 0;
	int unsigned          quiet_cycles = 0;
	int unsigned          send_gap     = 0;
	int unsigned          take_gap     = 0;
	int unsigned          stall_draw;
	bit                   send_sparse  = 1'b1;
	bit                   take_sparse  = 1'b1;
	bit                   in_taken     = 1'b0;
	bit                   out_taken    = 1'b0;

	always #5 clk = ~clk;

	// -----------------------------------------------------------------------
	// Slot model
	// -----------------------------------------------------------------------

	// a written count of 0 behaves as 1, anything above the slot count as full
	function automatic int unsigned span_of(input logic [rjs_pkg::ACTIVE_W-1:0] value);
		if (value == 0)
			return 1;
		if (value > SLOTS)
			return SLOTS;
		return 32'(value);
	endfunction

	function automatic void empty_slots();
		foreach (held_tag[i])
			held_tag[i] = rjs_pkg::TAG_EMPTY;
		held_count = 0;
	endfunction

	// apply one accepted transaction; on completing the rendezvous, queue the
	// whole release, highest slot first, slot 0 flagged last
	function automatic void absorb_item(input logic action,
			input logic [rjs_pkg::SLOT_W-1:0] slot,
			input logic [rjs_pkg::KIND_W-1:0] kind,
			input logic [rjs_pkg::DATA_W-1:0] payload);
		int unsigned                  n;
		rjs_pkg::tag_t                tag;
		logic [rjs_pkg::DATA_W-1:0]   val;
		rjs_pkg::tag_t                snap_tag [SLOTS];
		logic [rjs_pkg::DATA_W-1:0]   snap_val [SLOTS];
		release_t                     rel;

		n = span_of(span_reg);
		if (slot >= n)
			return;
		if (action == rjs_pkg::ACTION_CLEAR) begin
			// clear word empties everything on slot 0, elsewhere it is a list value
			if (slot == 0) begin
				empty_slots();
				return;
			end
			tag = rjs_pkg::TAG_LIST;
			val = payload;
		end else if (kind == rjs_pkg::KIND_BANG) begin
			tag = rjs_pkg::TAG_INT;
			val = '0;
		end else begin
			tag = rjs_pkg::tag_t'(kind);
			val = payload;
		end
		// only the first fill of a slot counts toward the rendezvous
		if (held_tag[slot] == rjs_pkg::TAG_EMPTY)
			held_count++;
		held_tag[slot] = tag;
		held_val[slot] = val;
		if (held_count < n)
			return;
		snap_tag = held_tag;
		snap_val = held_val;
		empty_slots();
		for (int s = n - 1; s >= 0; s--) begin
			rel.out_slot    = rjs_pkg::SLOT_W'(s);
			rel.out_kind    = rjs_pkg::KIND_W'(snap_tag[s] - 1);
			rel.out_payload = snap_val[s];
			rel.last        = (s == 0);
			release_q.push_back(rel);
		end
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------

	function automatic int unsigned draw_gap(input bit sparse);
		return sparse ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	// bias payloads towards all-zero, all-one and sign-bit patterns
	function automatic logic [rjs_pkg::DATA_W-1:0] any_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(rjs_pkg::DATA_W-1){1'b0}}};
			3: return {1'b0, {(rjs_pkg::DATA_W-1){1'b1}}};
			default: return $urandom();
		endcase
	endfunction

	task automatic push_item(input logic action, input int unsigned slot,
			input int unsigned kind, input logic [rjs_pkg::DATA_W-1:0] payload,
			input bit drain);
		join_item_t item;

		item.action      = action;
		item.slot_index  = rjs_pkg::SLOT_W'(slot);
		item.kind        = rjs_pkg::KIND_W'(kind);
		item.payload     = payload;
		item.drain_first = drain;
		stimulus_q.push_back(item);
		queued_total++;
	endtask

	// block until everything queued has been taken and every release seen,
	// then allow for a trailing clear still in flight
	task automatic wait_drained();
		while (taken_total != queued_total || release_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write the active count only once the block is idle; redraw idling style
	task automatic write_span(input logic [rjs_pkg::ACTIVE_W-1:0] value);
		wait_drained();
		send_sparse = ($urandom_range(0, 3) != 0);
		take_sparse = ($urandom_range(0, 3) != 0);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// mostly complete rounds in shuffled slot order with random content; the
	// rest is overwrites, broken rounds, out-of-range and unconstrained noise
	task automatic fill_randomly(input int unsigned span, input int unsigned quota);
		int unsigned counted;
		int unsigned order [SLOTS];
		int unsigned pick;
		int unsigned swap;
		int unsigned slot;
		int unsigned choice;
		logic        act;

		counted = 0;
		while (counted < quota) begin
			choice = $urandom_range(0, 9);
			if (choice < 7) begin
				for (int i = 0; i < span; i++)
					order[i] = i;
				for (int i = span - 1; i > 0; i--) begin
					pick        = $urandom_range(0, i);
					swap        = order[i];
					order[i]    = order[pick];
					order[pick] = swap;
				end
				for (int i = 0; i < span; i++) begin
					slot = order[i];
					act  = (slot != 0 && $urandom_range(0, 7) == 0) ?
						rjs_pkg::ACTION_CLEAR : rjs_pkg::ACTION_STORE;
					push_item(act, slot, $urandom_range(0, 3), any_word(),
						$urandom_range(0, 29) == 0);
					counted++;
					if ($urandom_range(0, 5) == 0) begin
						push_item(rjs_pkg::ACTION_STORE, slot, $urandom_range(0, 3),
							any_word(), 1'b0);
						counted++;
					end
					if ($urandom_range(0, 19) == 0) begin
						push_item(rjs_pkg::ACTION_CLEAR, 0, $urandom_range(0, 3),
							any_word(), 1'b0);
						counted++;
					end
				end
			end else if (choice == 7) begin
				push_item(rjs_pkg::ACTION_CLEAR, 0, $urandom_range(0, 3), any_word(), 1'b0);
				counted++;
			end else if (choice == 8 && span < SLOTS) begin
				// ignored by the block, so not counted
				push_item(1'($urandom_range(0, 1)), $urandom_range(span, SLOTS - 1),
					$urandom_range(0, 3), any_word(), 1'b0);
			end else begin
				slot = $urandom_range(0, SLOTS - 1);
				push_item(1'($urandom_range(0, 1)), slot, $urandom_range(0, 3),
					any_word(), 1'b0);
				if (slot < span)
					counted++;
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Driver: present queued transactions at the falling edge, hold each one
	// until taken, then idle for the drawn gap
	// -----------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			send_gap    <= 0;
		end else if (!in_ch.valid || in_taken) begin
			if (send_gap != 0) begin
				in_ch.valid <= 1'b0;
				send_gap    <= send_gap - 1;
			end else if (stimulus_q.size() != 0
					&& !(stimulus_q[0].drain_first && release_q.size() != 0)) begin
				next_item = stimulus_q.pop_front();
				in_ch.valid      <= 1'b1;
				in_ch.action     <= next_item.action;
				in_ch.slot_index <= next_item.slot_index;
				in_ch.kind       <= next_item.kind;
				in_ch.payload    <= next_item.payload;
				send_gap         <= draw_gap(send_sparse);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: after each released value, drop ready for the drawn stall
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			take_gap     <= 0;
		end else if (out_taken) begin
			stall_draw = draw_gap(take_sparse);
			out_ch.ready <= (stall_draw == 0);
			take_gap     <= (stall_draw == 0) ? 0 : stall_draw - 1;
		end else if (take_gap != 0) begin
			out_ch.ready <= 1'b0;
			take_gap     <= take_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: check released values first, then fold in the register write
	// and the inbound transaction of this edge
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		in_taken  <= arst_n && in_ch.valid && in_ch.ready;
		out_taken <= arst_n && out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (release_q.size() == 0) begin
					$error("unexpected release: slot %0d payload %h",
						out_ch.out_slot, out_ch.out_payload);
					mismatches++;
				end else begin
					if (out_ch.out_slot !== release_q[0].out_slot) begin
						$error("out_slot: expected %0d, got %0d",
							release_q[0].out_slot, out_ch.out_slot);
						mismatches++;
					end
					if (out_ch.out_kind !== release_q[0].out_kind) begin
						$error("out_kind: expected %0d, got %0d",
							release_q[0].out_kind, out_ch.out_kind);
						mismatches++;
					end
					if (out_ch.out_payload !== release_q[0].out_payload) begin
						$error("out_payload: expected %h, got %h",
							release_q[0].out_payload, out_ch.out_payload);
						mismatches++;
					end
					if (out_ch.last !== release_q[0].last) begin
						$error("last: expected %0d, got %0d",
							release_q[0].last, out_ch.last);
						mismatches++;
					end
					void'(release_q.pop_front());
				end
			end
			// any write of the count empties every slot
			if (cfg_we) begin
				span_reg = cfg_wdata;
				empty_slots();
			end
			if (in_ch.valid && in_ch.ready) begin
				absorb_item(in_ch.action, in_ch.slot_index, in_ch.kind, in_ch.payload);
				taken_total++;
			end
		end
	end

	// Watchdog: abandon the run after too long without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Sequence of the run
	// -----------------------------------------------------------------------
	initial begin
		logic [rjs_pkg::ACTIVE_W-1:0] phase_span [PHASES];

		phase_span = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd9, 4'd4, 4'd7, 4'd6, 4'd2, 4'd8};

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		in_ch.valid      = 1'b0;
		in_ch.action     = rjs_pkg::ACTION_STORE;
		in_ch.slot_index = '0;
		in_ch.kind       = rjs_pkg::KIND_BANG;
		in_ch.payload    = '0;
		out_ch.ready     = 1'b0;
		span_reg         = rjs_pkg::ACTIVE_RESET;
		empty_slots();

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset width of two slots
		push_item(rjs_pkg::ACTION_STORE, 0, rjs_pkg::KIND_BANG, '1, 1'b0);   // bang stores 0
		push_item(rjs_pkg::ACTION_STORE, 1, rjs_pkg::KIND_INT, '1, 1'b0);    // completes
		push_item(rjs_pkg::ACTION_STORE, 7, rjs_pkg::KIND_FLOAT, 32'h3f80_0000, 1'b0);
		push_item(rjs_pkg::ACTION_STORE, 0, rjs_pkg::KIND_FLOAT, 32'h3f80_0000, 1'b1);
		push_item(rjs_pkg::ACTION_CLEAR, 0, rjs_pkg::KIND_LIST, 32'h1234_5678, 1'b0);
		push_item(rjs_pkg::ACTION_STORE, 1, rjs_pkg::KIND_LIST, '0, 1'b0);
		push_item(rjs_pkg::ACTION_STORE, 1, rjs_pkg::KIND_INT, 32'h8000_0000, 1'b0);
		push_item(rjs_pkg::ACTION_CLEAR, 1, rjs_pkg::KIND_FLOAT, 32'ha5a5_a5a5, 1'b0);
		push_item(rjs_pkg::ACTION_STORE, 0, rjs_pkg::KIND_FLOAT, 32'h7fc0_0000, 1'b0);
		push_item(rjs_pkg::ACTION_CLEAR, 2, rjs_pkg::KIND_INT, '1, 1'b0);    // out of range
		push_item(rjs_pkg::ACTION_CLEAR, 0, rjs_pkg::KIND_BANG, '0, 1'b0);   // clear when empty
		push_item(rjs_pkg::ACTION_STORE, 0, rjs_pkg::KIND_INT, 32'h0000_0001, 1'b0);
		push_item(rjs_pkg::ACTION_STORE, 1, rjs_pkg::KIND_INT, 32'h7fff_ffff, 1'b0);

		// single slot: every store releases at once
		write_span(4'd1);
		push_item(rjs_pkg::ACTION_STORE, 0, rjs_pkg::KIND_INT, 32'h0000_0005, 1'b0);
		push_item(rjs_pkg::ACTION_CLEAR, 0, rjs_pkg::KIND_LIST, '1, 1'b0);

		// zero behaves as one slot
		write_span(4'd0);
		push_item(rjs_pkg::ACTION_STORE, 0, rjs_pkg::KIND_FLOAT, 32'hff80_0000, 1'b0);

		// above the slot count behaves as all eight
		write_span(4'd15);
		for (int s = SLOTS - 1; s >= 0; s--)
			push_item(s == 3 ? rjs_pkg::ACTION_CLEAR : rjs_pkg::ACTION_STORE, s, s % 4,
				any_word(), 1'b0);

		// random phases across several widths, extremes included
		for (int p = 0; p < PHASES; p++) begin
			write_span(phase_span[p]);
			fill_randomly(span_of(phase_span[p]), RANDOM_ITEMS / PHASES + 1);
		end

		wait_drained();
		if (mismatches == 0 && release_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
